// File: rtl/core/window_stack_hit_test_top_defines.svh
// Assertion macros shared by the window stack hit test modules.
`ifndef WINDOW_STACK_HIT_TEST_TOP_DEFINES_SVH
`define WINDOW_STACK_HIT_TEST_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define WSHT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define WSHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/wsht_pkg.sv
// Package with the types, constants and codes of the window stack hit test.
`timescale 1ns / 1ps

package wsht_pkg;

   // Default configuration of the block.
   localparam int MAX_WINDOWS_DEF = 16;
   localparam int COORD_BITS_DEF  = 12;

   // Fixed widths of the result fields.
   localparam int STATUS_W = 2;
   localparam int NUM_W    = 5;

   // Request action codes.
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_CLICK = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_HIT     = 2'd0,
      ST_IGNORED = 2'd1,
      ST_LOADED  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      CS_IDLE,
      CS_LOAD,
      CS_CLICK,
      CS_SCAN,
      CS_SHIFT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       load_write;
      logic       scan_init;
      logic       scan_step;
      logic       shift_init;
      logic       shift_step;
      logic       resp_en;
      status_type resp_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic hit;
      logic miss_done;
      logic shift_last;
   } stat_type;

endpackage

// File: rtl/core/wsht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module wsht_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/wsht_ctrl.sv
// Controller state machine that sequences loads, scans and reordering.
`timescale 1ns / 1ps
`include "window_stack_hit_test_top_defines.svh"

module wsht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              req_action,
   input  wsht_pkg::stat_type stat,
   output wsht_pkg::cmd_type  cmd,
   output logic              busy
);

   import wsht_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         CS_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = req_action ? CS_CLICK : CS_LOAD;
            end
         end
         CS_LOAD: begin
            cmd.resp_en = 1'b1;
            if (stat.full) begin
               cmd.resp_status = ST_FULL;
            end else begin
               cmd.load_write  = 1'b1;
               cmd.resp_status = ST_LOADED;
            end
            state_in = CS_IDLE;
         end
         CS_CLICK: begin
            if (stat.empty) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_IGNORED;
               state_in        = CS_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = CS_SCAN;
            end
         end
         CS_SCAN: begin
            if (stat.hit) begin
               cmd.shift_init = 1'b1;
               state_in       = CS_SHIFT;
            end else if (stat.miss_done) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_IGNORED;
               state_in        = CS_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         CS_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_last) begin
               cmd.resp_en     = 1'b1;
               cmd.resp_status = ST_HIT;
               state_in        = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // An accepted request always leaves the idle state, and every result ends the request.
   `WSHT_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, start && !busy, state_ff != CS_IDLE, "accepted request did not start work")
   `WSHT_ASSERT_NEXT(a_resp_ends_request, clock, reset, cmd.resp_en, state_ff == CS_IDLE, "result issued without returning to idle")

endmodule

// File: rtl/core/wsht_datapath.sv
// Datapath: window store, stack order store, scan pipeline and result register.
`timescale 1ns / 1ps
`include "window_stack_hit_test_top_defines.svh"

module wsht_datapath #(
   parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
   parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wsht_pkg::cmd_type            cmd,
   output wsht_pkg::stat_type           stat,
   input  logic [COORD_BITS-1:0]        req_left_x,
   input  logic [COORD_BITS-1:0]        req_bottom_y,
   input  logic [COORD_BITS-1:0]        req_right_x,
   input  logic [COORD_BITS-1:0]        req_top_y,
   input  logic [COORD_BITS-1:0]        req_click_x,
   input  logic [COORD_BITS-1:0]        req_click_y,
   output logic                         rsp_valid,
   output logic [wsht_pkg::STATUS_W-1:0] rsp_status,
   output logic [wsht_pkg::NUM_W-1:0]    rsp_window_number
);

   import wsht_pkg::*;

   localparam int SLOT_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CNT_W  = $clog2(MAX_WINDOWS + 1);
   localparam int RECT_W = 4 * COORD_BITS;

   // Latched request fields.
   logic [COORD_BITS-1:0] left_ff, bottom_ff, right_ff, top_ff, pt_x_ff, pt_y_ff;

   // Control registers and their next values.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] iss_pos_ff, iss_pos_in;
   logic [CNT_W-1:0]  iss_left_ff, iss_left_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [SLOT_W-1:0] s1_pos_ff, s1_pos_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [SLOT_W-1:0] s2_pos_ff, s2_pos_in;
   logic [SLOT_W-1:0] s2_slot_ff, s2_slot_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic [SLOT_W-1:0] sh_wr_ff, sh_wr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]  rsp_number_ff, rsp_number_in;

   // Memory ports.
   logic              order_wr_en;
   logic [SLOT_W-1:0] order_wr_addr, order_wr_data, order_rd_addr, order_rd_data;
   logic [RECT_W-1:0] rect_wr_data, rect_rd_data;

   logic [CNT_W-1:0]      count_m1;
   logic [SLOT_W-1:0]     top_pos;
   logic [COORD_BITS-1:0] r_left, r_bottom, r_right, r_top;
   logic                  contains;
   logic [31:0]           hit_num_wide, load_num_wide;

   // Topmost occupied stack position.
   assign count_m1 = count_ff - CNT_W'(1);
   assign top_pos  = count_m1[SLOT_W-1:0];

   // Stack order store: one slot number per stack position.
   always_comb begin
      order_rd_addr = iss_pos_ff;
      if (cmd.shift_init) begin
         order_rd_addr = s2_pos_ff + SLOT_W'(1);
      end else if (cmd.shift_step) begin
         order_rd_addr = sh_wr_ff + SLOT_W'(2);
      end
      order_wr_en = cmd.load_write | cmd.shift_step;
      if (cmd.load_write) begin
         order_wr_addr = count_ff[SLOT_W-1:0];
         order_wr_data = count_ff[SLOT_W-1:0];
      end else begin
         order_wr_addr = sh_wr_ff;
         order_wr_data = stat.shift_last ? hit_slot_ff : order_rd_data;
      end
   end

   wsht_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (MAX_WINDOWS),
      .ADDR_W(SLOT_W)
   ) u_order_ram (
      .clock  (clock),
      .wr_en  (order_wr_en),
      .wr_addr(order_wr_addr),
      .wr_data(order_wr_data),
      .rd_addr(order_rd_addr),
      .rd_data(order_rd_data)
   );

   // Rectangle store, read at the slot just fetched from the stack order.
   assign rect_wr_data = {top_ff, right_ff, bottom_ff, left_ff};

   wsht_ram #(
      .WIDTH (RECT_W),
      .DEPTH (MAX_WINDOWS),
      .ADDR_W(SLOT_W)
   ) u_rect_ram (
      .clock  (clock),
      .wr_en  (cmd.load_write),
      .wr_addr(count_ff[SLOT_W-1:0]),
      .wr_data(rect_wr_data),
      .rd_addr(order_rd_data),
      .rd_data(rect_rd_data)
   );

   // Inclusive point-in-rectangle test.
   assign r_left   = rect_rd_data[COORD_BITS-1:0];
   assign r_bottom = rect_rd_data[2*COORD_BITS-1:COORD_BITS];
   assign r_right  = rect_rd_data[3*COORD_BITS-1:2*COORD_BITS];
   assign r_top    = rect_rd_data[4*COORD_BITS-1:3*COORD_BITS];
   assign contains = (pt_x_ff >= r_left) && (pt_x_ff <= r_right) &&
                     (pt_y_ff >= r_bottom) && (pt_y_ff <= r_top);

   // Status towards the controller.
   always_comb begin
      stat.full       = (count_ff == CNT_W'(MAX_WINDOWS));
      stat.empty      = (count_ff == '0);
      stat.hit        = s2_valid_ff && contains;
      stat.miss_done  = s2_valid_ff && !contains && (s2_pos_ff == '0);
      stat.shift_last = (sh_wr_ff == top_pos);
   end

   // Window numbers count from one.
   assign hit_num_wide  = 32'(hit_slot_ff) + 32'd1;
   assign load_num_wide = 32'(count_ff) + 32'd1;

   // Next values of the control registers.
   always_comb begin
      count_in      = count_ff;
      iss_pos_in    = iss_pos_ff;
      iss_left_in   = iss_left_ff;
      s1_valid_in   = s1_valid_ff;
      s1_pos_in     = s1_pos_ff;
      s2_valid_in   = s2_valid_ff;
      s2_pos_in     = s2_pos_ff;
      s2_slot_in    = s2_slot_ff;
      hit_slot_in   = hit_slot_ff;
      sh_wr_in      = sh_wr_ff;
      rsp_valid_in  = cmd.resp_en;
      rsp_status_in = cmd.resp_status;
      case (cmd.resp_status)
         ST_HIT:    rsp_number_in = hit_num_wide[NUM_W-1:0];
         ST_LOADED: rsp_number_in = load_num_wide[NUM_W-1:0];
         default:   rsp_number_in = '0;
      endcase

      if (cmd.load_write) begin
         count_in = count_ff + CNT_W'(1);
      end

      // Scan from the top of the stack downwards, one position issued per cycle.
      if (cmd.scan_init) begin
         iss_pos_in  = top_pos;
         iss_left_in = count_ff;
         s1_valid_in = 1'b0;
         s2_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         if (iss_left_ff != '0) begin
            s1_valid_in = 1'b1;
            s1_pos_in   = iss_pos_ff;
            iss_pos_in  = iss_pos_ff - SLOT_W'(1);
            iss_left_in = iss_left_ff - CNT_W'(1);
         end else begin
            s1_valid_in = 1'b0;
         end
         s2_valid_in = s1_valid_ff;
         s2_pos_in   = s1_pos_ff;
         s2_slot_in  = order_rd_data;
      end

      // Move the windows above the hit down by one position.
      if (cmd.shift_init) begin
         hit_slot_in = s2_slot_ff;
         sh_wr_in    = s2_pos_ff;
      end else if (cmd.shift_step) begin
         sh_wr_in = sh_wr_ff + SLOT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         iss_left_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         iss_left_ff  <= iss_left_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff   <= req_left_x;
         bottom_ff <= req_bottom_y;
         right_ff  <= req_right_x;
         top_ff    <= req_top_y;
         pt_x_ff   <= req_click_x;
         pt_y_ff   <= req_click_y;
      end
      iss_pos_ff    <= iss_pos_in;
      s1_pos_ff     <= s1_pos_in;
      s2_pos_ff     <= s2_pos_in;
      s2_slot_ff    <= s2_slot_in;
      hit_slot_ff   <= hit_slot_in;
      sh_wr_ff      <= sh_wr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_number_ff <= rsp_number_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_window_number = rsp_number_ff;

   // Occupancy stays in range, and scans and shifts touch only occupied positions.
   `WSHT_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_WINDOWS), "window count above capacity")
   `WSHT_ASSERT_IMP(a_hit_in_stack, clock, reset, stat.hit, CNT_W'(s2_pos_ff) < count_ff, "hit reported outside the stack")
   `WSHT_ASSERT_IMP(a_shift_in_stack, clock, reset, cmd.shift_step, CNT_W'(sh_wr_ff) < count_ff, "reorder write outside the stack")

endmodule

// File: rtl/core/window_stack_hit_test_top.sv
// A load stores its window on top of the stack, or reports full; a click on an empty
// stack is ignored. Otherwise a click scans the stack serially from the top down
// through the single read port of the stack-order memory; a miss is ignored, and a
// hit moves the windows above it down one position and puts the hit window on top.
// A new request is taken once busy is low; results are strobed for one cycle and
// cannot be stalled. Reset empties the stack at once; the memories are not cleared.
`timescale 1ns / 1ps

module window_stack_hit_test_top #(
   parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF,
   parameter int COORD_BITS  = wsht_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [COORD_BITS-1:0]         req_left_x,
   input  logic [COORD_BITS-1:0]         req_bottom_y,
   input  logic [COORD_BITS-1:0]         req_right_x,
   input  logic [COORD_BITS-1:0]         req_top_y,
   input  logic [COORD_BITS-1:0]         req_click_x,
   input  logic [COORD_BITS-1:0]         req_click_y,
   output logic                          rsp_valid,
   output logic [wsht_pkg::STATUS_W-1:0] rsp_status,
   output logic [wsht_pkg::NUM_W-1:0]    rsp_window_number
);

   import wsht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   wsht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_action(req_action),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   // Stores, scan pipeline and result register.
   wsht_datapath #(
      .MAX_WINDOWS(MAX_WINDOWS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_left_x       (req_left_x),
      .req_bottom_y     (req_bottom_y),
      .req_right_x      (req_right_x),
      .req_top_y        (req_top_y),
      .req_click_x      (req_click_x),
      .req_click_y      (req_click_y),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_window_number(rsp_window_number)
   );

endmodule

// File: tb/sv/window_stack_hit_test_monitor.sv
// Monitor that predicts and checks the results of the window stack hit test.
`timescale 1ns / 1ps

module window_stack_hit_test_monitor
   import wsht_pkg::*;
#(
   parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_action,
   input  logic [COORD_BITS-1:0] req_left_x,
   input  logic [COORD_BITS-1:0] req_bottom_y,
   input  logic [COORD_BITS-1:0] req_right_x,
   input  logic [COORD_BITS-1:0] req_top_y,
   input  logic [COORD_BITS-1:0] req_click_x,
   input  logic [COORD_BITS-1:0] req_click_y,
   input  logic                  rsp_valid,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [NUM_W-1:0]      rsp_window_number,
   output int                    failures,
   output int                    pending
);

   typedef struct packed {
      status_type       status;
      logic [NUM_W-1:0] number;
   } outcome_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_lo;
      logic [COORD_BITS-1:0] y_lo;
      logic [COORD_BITS-1:0] x_hi;
      logic [COORD_BITS-1:0] y_hi;
   } rect_type;

   // Own copy of the window store and the stacking order (position 0 is the bottom).
   rect_type    windows [MAX_WINDOWS];
   int          order [MAX_WINDOWS];
   int          stacked;
   int          mismatches;
   outcome_type outcomes_due [$];

   initial begin
      stacked    = 0;
      mismatches = 0;
      failures   = 0;
      pending    = 0;
   end

   // Applies one request to the stack and returns the result it should give.
   function automatic outcome_type apply_request(
      input logic                  action,
      input logic [COORD_BITS-1:0] x_lo,
      input logic [COORD_BITS-1:0] y_lo,
      input logic [COORD_BITS-1:0] x_hi,
      input logic [COORD_BITS-1:0] y_hi,
      input logic [COORD_BITS-1:0] px,
      input logic [COORD_BITS-1:0] py
   );
      outcome_type res;
      int          slot;
      bit          found;
      res.status = ST_IGNORED;
      res.number = '0;
      found      = 1'b0;
      if (action == ACT_LOAD) begin
         // A load takes the next slot and goes on top, unless the stack is full.
         if (stacked >= MAX_WINDOWS) begin
            res.status = ST_FULL;
         end else begin
            windows[stacked] = '{x_lo, y_lo, x_hi, y_hi};
            order[stacked]   = stacked;
            stacked++;
            res.status = ST_LOADED;
            res.number = NUM_W'(stacked);
         end
      end else begin
         // A click scans from the top down and brings the first window hit to the top.
         for (int pos = stacked - 1; pos >= 0 && !found; pos--) begin
            slot = order[pos];
            if (px >= windows[slot].x_lo && px <= windows[slot].x_hi &&
                py >= windows[slot].y_lo && py <= windows[slot].y_hi) begin
               found = 1'b1;
               for (int k = pos; k < stacked - 1; k++) begin
                  order[k] = order[k + 1];
               end
               order[stacked - 1] = slot;
               res.status = ST_HIT;
               res.number = NUM_W'(slot + 1);
            end
         end
      end
      return res;
   endfunction

   // Results are compared before the request of the same edge is predicted.
   always @(posedge clock) begin
      outcome_type due;
      if (reset) begin
         stacked = 0;
         outcomes_due.delete();
      end else begin
         if (rsp_valid) begin
            if (outcomes_due.size() == 0) begin
               $error("unexpected result: status %0d, window_number %0d",
                      rsp_status, rsp_window_number);
               mismatches++;
            end else begin
               due = outcomes_due.pop_front();
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, actual %0d", due.status, rsp_status);
                  mismatches++;
               end
               if (rsp_window_number !== due.number) begin
                  $error("window_number: expected %0d, actual %0d",
                         due.number, rsp_window_number);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            outcomes_due.insert(outcomes_due.size(),
                                apply_request(req_action, req_left_x, req_bottom_y,
                                              req_right_x, req_top_y,
                                              req_click_x, req_click_y));
         end
      end
      failures <= mismatches;
      pending  <= outcomes_due.size();
   end

endmodule

// File: tb/sv/tb_window_stack_hit_test_top.sv
// Testbench top that drives requests into the window stack hit test and gives the verdict.
`timescale 1ns / 1ps

module tb_window_stack_hit_test_top;
   import wsht_pkg::*;

   localparam int   MAX_WINDOWS     = MAX_WINDOWS_DEF;
   localparam int   COORD_BITS      = COORD_BITS_DEF;
   localparam int   COORD_MAX       = (1 << COORD_BITS) - 1;
   localparam int   RANDOM_REQUESTS = 850;
   localparam int   STALL_LIMIT     = 1000;
   localparam int   DRAIN_CYCLES    = 48;

   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic                  req_action   = ACT_LOAD;
   logic [COORD_BITS-1:0] req_left_x   = '0;
   logic [COORD_BITS-1:0] req_bottom_y = '0;
   logic [COORD_BITS-1:0] req_right_x  = '0;
   logic [COORD_BITS-1:0] req_top_y    = '0;
   logic [COORD_BITS-1:0] req_click_x  = '0;
   logic [COORD_BITS-1:0] req_click_y  = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [NUM_W-1:0]      rsp_window_number;
   int                    failures;
   int                    pending;

   // Rectangles that were loaded, kept only to aim clicks at them.
   int shape_x_lo [MAX_WINDOWS];
   int shape_y_lo [MAX_WINDOWS];
   int shape_x_hi [MAX_WINDOWS];
   int shape_y_hi [MAX_WINDOWS];
   int shapes     = 0;
   int burst_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   window_stack_hit_test_top uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_left_x        (req_left_x),
      .req_bottom_y      (req_bottom_y),
      .req_right_x       (req_right_x),
      .req_top_y         (req_top_y),
      .req_click_x       (req_click_x),
      .req_click_y       (req_click_y),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_window_number (rsp_window_number)
   );

   window_stack_hit_test_monitor hit_test_watch (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_left_x        (req_left_x),
      .req_bottom_y      (req_bottom_y),
      .req_right_x       (req_right_x),
      .req_top_y         (req_top_y),
      .req_click_x       (req_click_x),
      .req_click_y       (req_click_y),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_window_number (rsp_window_number),
      .failures          (failures),
      .pending           (pending)
   );

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   // Presents one request, holds it until it is taken, then maybe pauses the burst.
   task automatic send_request(input logic action, input int x_lo, input int y_lo,
                               input int x_hi, input int y_hi, input int px, input int py);
      req_action   <= action;
      req_left_x   <= COORD_BITS'(x_lo);
      req_bottom_y <= COORD_BITS'(y_lo);
      req_right_x  <= COORD_BITS'(x_hi);
      req_top_y    <= COORD_BITS'(y_hi);
      req_click_x  <= COORD_BITS'(px);
      req_click_y  <= COORD_BITS'(py);
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // A load carries random values in the unused click fields.
   task automatic send_load(input int x_lo, input int y_lo, input int x_hi, input int y_hi);
      if (shapes < MAX_WINDOWS) begin
         shape_x_lo[shapes] = x_lo;
         shape_y_lo[shapes] = y_lo;
         shape_x_hi[shapes] = x_hi;
         shape_y_hi[shapes] = y_hi;
         shapes++;
      end
      send_request(ACT_LOAD, x_lo, y_lo, x_hi, y_hi,
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
   endtask

   // A click carries random values in the unused rectangle fields.
   task automatic send_click(input int px, input int py);
      send_request(ACT_CLICK, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), px, py);
   endtask

   // Clicks inside a loaded window, or on and just beyond its border; anywhere if it is inverted.
   task automatic aim_click(input bit on_border);
      int idx;
      int px;
      int py;
      idx = $urandom_range(0, shapes - 1);
      if (shape_x_lo[idx] > shape_x_hi[idx] || shape_y_lo[idx] > shape_y_hi[idx]) begin
         px = $urandom_range(0, COORD_MAX);
         py = $urandom_range(0, COORD_MAX);
      end else if (!on_border) begin
         px = $urandom_range(shape_x_lo[idx], shape_x_hi[idx]);
         py = $urandom_range(shape_y_lo[idx], shape_y_hi[idx]);
      end else begin
         case ($urandom_range(0, 3))
            0: px = shape_x_lo[idx];
            1: px = shape_x_hi[idx];
            2: px = clamp_coord(shape_x_lo[idx] - 1);
            default: px = clamp_coord(shape_x_hi[idx] + 1);
         endcase
         case ($urandom_range(0, 3))
            0: py = shape_y_lo[idx];
            1: py = shape_y_hi[idx];
            2: py = clamp_coord(shape_y_lo[idx] - 1);
            default: py = clamp_coord(shape_y_hi[idx] + 1);
         endcase
      end
      send_click(px, py);
   endtask

   // Random rectangle of moderate size, now and then inverted.
   task automatic random_load();
      int x_lo;
      int y_lo;
      int x_hi;
      int y_hi;
      x_lo = $urandom_range(0, COORD_MAX);
      y_lo = $urandom_range(0, COORD_MAX);
      x_hi = clamp_coord(x_lo + $urandom_range(0, 1200));
      y_hi = clamp_coord(y_lo + $urandom_range(0, 1200));
      case ($urandom_range(0, 9))
         0: send_load(x_hi, y_lo, x_lo, y_hi);
         1: send_load(x_lo, y_hi, x_hi, y_lo);
         default: send_load(x_lo, y_lo, x_hi, y_hi);
      endcase
   endtask

   // Stimulus: directed requests, then random ones, then drain and verdict.
   initial begin
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Clicks on an empty stack are ignored.
      send_request(ACT_CLICK, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0);
      send_request(ACT_CLICK, 0, 0, 0, 0, COORD_MAX, COORD_MAX);

      // Edge strips, inverted rectangles, single-point windows and an inner square.
      send_load(0, 0, COORD_MAX, 10);
      send_load(0, COORD_MAX - 10, COORD_MAX, COORD_MAX);
      send_load(3000, 0, 1000, COORD_MAX);
      send_load(0, 3000, COORD_MAX, 1000);
      send_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_load(0, 0, 0, 0);
      send_load(1000, 1000, 2000, 2000);

      // Hits below the top, the deepest window, the top one, borders and misses.
      send_click(COORD_MAX, COORD_MAX);
      send_click(0, 0);
      send_click(0, 5);
      send_click(1000, 1000);
      send_click(2000, 2000);
      send_click(999, 1500);
      send_click(2001, 2000);
      send_click(2000, COORD_MAX);
      send_click(3000, 2000);

      // Mostly aimed clicks; loads fill the stack and then keep hitting the full case.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < ((shapes < MAX_WINDOWS) ? 15 : 5)) begin
            random_load();
         end else if (pick < 70) begin
            aim_click(1'b0);
         end else if (pick < 85) begin
            aim_click(1'b1);
         end else begin
            send_click($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
         end
      end
      start <= 1'b0;

      // Wait for every outstanding result, then a little longer for strays.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("window_stack_hit_test_top: match");
      end else begin
         $display("window_stack_hit_test_top: mismatch");
      end
      $finish;
   end

   // Watchdog: ends the run when neither a request nor a result moves for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("window_stack_hit_test_top: mismatch");
      $finish;
   end

endmodule

// File: window_stack_hit_test_top.f
+incdir+rtl/core
rtl/core/wsht_pkg.sv
rtl/core/wsht_ram.sv
rtl/core/wsht_ctrl.sv
rtl/core/wsht_datapath.sv
rtl/core/window_stack_hit_test_top.sv
tb/sv/window_stack_hit_test_monitor.sv
tb/sv/tb_window_stack_hit_test_top.sv
